@@ sv/pvst_pkg.sv @@
package pvst_pkg;

    localparam int MAX_ATOMS  = 4096;
    localparam int COMPONENTS = 6;
    localparam int ROW_AW     = $clog2(MAX_ATOMS);
    localparam int ATOM_W     = 12;
    localparam int NLOC_W     = 13;
    localparam int FIX_W      = 32;
    localparam int VAL_W      = 64;
    localparam int ROW_W      = VAL_W * COMPONENTS;
    localparam int EPOCH_W    = 8;
    localparam int COMP_W     = 3;
    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 448;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int DIV_CHUNK  = 16;
    localparam int DIV_CYC    = VAL_W / DIV_CHUNK;
    localparam int DIV_CNT_W  = $clog2(DIV_CYC);
    localparam int DIV_NUM_W  = DIV_CHUNK + 2;
    localparam int DIV_RECIP_SH = DIV_CHUNK + 3;
    // ceil(2^19 / 3): exact quotient for any numerator below 2^18
    localparam logic [DIV_NUM_W-1:0] DIV_RECIP = DIV_NUM_W'((2**DIV_RECIP_SH + 1) / 3);

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_PAIR = 2'd0,
        KIND_ROW  = 2'd1,
        KIND_GLOB = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     clear;
        logic [ATOM_W-1:0]        ia;
        logic [ATOM_W-1:0]        ib;
        logic                     tally_a;
        logic                     tally_b;
        logic                     ia_ok;
        logic signed [FIX_W-1:0]  force_v;
        logic signed [FIX_W-1:0]  dx;
        logic signed [FIX_W-1:0]  dy;
        logic signed [FIX_W-1:0]  dz;
    } cmd_t;

    typedef struct packed {
        logic             start;
        val_t             a;
        logic [FIX_W-1:0] bmag;
        logic             bneg;
        logic             s17;
    } ms_req_t;

    typedef struct packed {
        logic done;
        val_t res;
    } ms_rsp_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_ABS,
        MS_LO,
        MS_HI,
        MS_Q,
        MS_FIN
    } ms_state_t;

    typedef enum logic [3:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_VSEP,
        BK_VGO,
        BK_VWAIT,
        BK_TRD,
        BK_TWR,
        BK_RRD,
        BK_RLOAD,
        BK_SGO,
        BK_SWAIT,
        BK_TR1,
        BK_TR2,
        BK_DIVINIT,
        BK_DIV,
        BK_OUT
    } bk_state_t;

    function automatic val_t sat_add(val_t a, val_t b);
        val_t s;
        s = a + b;
        if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1]) begin
            s = a[VAL_W-1] ? VAL_MIN : VAL_MAX;
        end
        return s;
    endfunction

endpackage

@@ sv/pvst_front.sv @@
module pvst_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pvst_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output pvst_pkg::cmd_t                 q_din
);
    import pvst_pkg::*;

    logic [FIX_W-1:0]  last_step_reg, last_step_next;
    logic              step_seen_reg, step_seen_next;
    kind_t             kind;
    logic              accept;
    logic [FIX_W-1:0]  ts;
    logic [ATOM_W-1:0] ia, ib;
    logic [NLOC_W-1:0] nloc;
    logic              newton;

    assign kind     = kind_t'(s_tuser);
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign ts       = s_tdata[31:0];
    assign ia       = s_tdata[43:32];
    assign ib       = s_tdata[55:44];
    assign nloc     = s_tdata[68:56];
    assign newton   = s_tdata[69];

    always_comb begin
        last_step_next = last_step_reg;
        step_seen_next = step_seen_reg;
        q_push = accept && (kind != KIND_NONE);
        q_din.kind    = kind;
        q_din.clear   = (kind == KIND_PAIR) && (!step_seen_reg || ts != last_step_reg);
        q_din.ia      = ia;
        q_din.ib      = ib;
        q_din.ia_ok   = 32'(ia) < 32'(MAX_ATOMS);
        q_din.tally_a = (newton || 13'(ia) < nloc) && q_din.ia_ok;
        q_din.tally_b = (newton || 13'(ib) < nloc) && (32'(ib) < 32'(MAX_ATOMS));
        q_din.force_v = s_tdata[101:70];
        q_din.dx      = s_tdata[133:102];
        q_din.dy      = s_tdata[165:134];
        q_din.dz      = s_tdata[197:166];
        if (accept && kind == KIND_PAIR) begin
            last_step_next = ts;
            step_seen_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_step_reg <= '0;
            step_seen_reg <= 1'b0;
        end else begin
            last_step_reg <= last_step_next;
            step_seen_reg <= step_seen_next;
        end
    end

endmodule

@@ sv/pvst_queue.sv @@
module pvst_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pvst_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output pvst_pkg::cmd_t dout,
    output logic           empty
);
    import pvst_pkg::*;

    cmd_t              ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == (QPTR_W+1)'(QDEPTH);
    assign empty = cnt_reg == '0;
    assign dout  = ent_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = wp_reg + 1'b1;
        end
        if (pop) begin
            rp_next = rp_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ sv/pvst_mulsh.sv @@
module pvst_mulsh (
    input  logic              aclk,
    input  logic              aresetn,
    input  pvst_pkg::ms_req_t req,
    output pvst_pkg::ms_rsp_t rsp
);
    import pvst_pkg::*;

    ms_state_t        state_reg, state_next;
    val_t             a_reg, a_next;
    logic [FIX_W-1:0] b_reg, b_next;
    logic             bneg_reg, bneg_next;
    logic             s17_reg, s17_next;
    logic [VAL_W-1:0] amag_reg, amag_next;
    logic             neg_reg, neg_next;
    logic [VAL_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [VAL_W:0]   q_reg, q_next;
    logic             sat_reg, sat_next;
    logic             zero_reg, zero_next;
    val_t             res_reg, res_next;
    logic             done_reg, done_next;
    logic [VAL_W:0]   hi_sh, lo_r;

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        bneg_next  = bneg_reg;
        s17_next   = s17_reg;
        amag_next  = amag_reg;
        neg_next   = neg_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        q_next     = q_reg;
        sat_next   = sat_reg;
        zero_next  = zero_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        hi_sh = s17_reg ? ({1'b0, hi_reg} << 15) : ({1'b0, hi_reg} << 16);
        lo_r  = {1'b0, lo_reg} + (neg_reg ? (s17_reg ? 65'h1FFFF : 65'hFFFF) : 65'h0);
        unique case (state_reg)
            MS_IDLE: begin
                if (req.start) begin
                    a_next     = req.a;
                    b_next     = req.bmag;
                    bneg_next  = req.bneg;
                    s17_next   = req.s17;
                    state_next = MS_ABS;
                end
            end
            MS_ABS: begin
                amag_next  = a_reg[VAL_W-1] ? VAL_W'(-a_reg) : VAL_W'(a_reg);
                neg_next   = a_reg[VAL_W-1] ^ bneg_reg;
                state_next = MS_LO;
            end
            MS_LO: begin
                lo_next    = amag_reg[31:0] * b_reg;
                state_next = MS_HI;
            end
            MS_HI: begin
                hi_next    = amag_reg[63:32] * b_reg;
                state_next = MS_Q;
            end
            MS_Q: begin
                sat_next   = s17_reg ? (hi_reg[63:48] != '0) : (hi_reg[63:47] != '0);
                zero_next  = (amag_reg == '0) || (b_reg == '0);
                q_next     = hi_sh + (s17_reg ? (lo_r >> 17) : (lo_r >> 16));
                state_next = MS_FIN;
            end
            MS_FIN: begin
                if (zero_reg) begin
                    res_next = '0;
                end else if (sat_reg) begin
                    res_next = neg_reg ? VAL_MIN : VAL_MAX;
                end else if (!neg_reg) begin
                    res_next = (q_reg[64] || q_reg[63]) ? VAL_MAX : val_t'(q_reg[63:0]);
                end else begin
                    res_next = (q_reg[64] || q_reg[63]) ? VAL_MIN : val_t'(-q_reg[63:0]);
                end
                done_next  = 1'b1;
                state_next = MS_IDLE;
            end
            default: state_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        bneg_reg <= bneg_next;
        s17_reg  <= s17_next;
        amag_reg <= amag_next;
        neg_reg  <= neg_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        q_reg    <= q_next;
        sat_reg  <= sat_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

@@ sv/pvst_back.sv @@
module pvst_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [pvst_pkg::FIX_W-1:0]      pressure_scale,
    input  logic                            q_empty,
    input  pvst_pkg::cmd_t                  q_dout,
    output logic                            q_pop,
    output pvst_pkg::ms_req_t               ms_req,
    input  pvst_pkg::ms_rsp_t               ms_rsp,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pvst_pkg::OUT_DATA_W-1:0] m_tdata
);
    import pvst_pkg::*;

    bk_state_t              state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [COMP_W-1:0]      comp_reg, comp_next;
    logic                   sel_reg, sel_next;
    val_t                   v_reg [COMPONENTS];
    val_t                   v_next [COMPONENTS];
    val_t                   w_reg [COMPONENTS];
    val_t                   w_next [COMPONENTS];
    val_t                   s_reg [COMPONENTS];
    val_t                   s_next [COMPONENTS];
    val_t                   glob_reg [COMPONENTS];
    val_t                   glob_next [COMPONENTS];
    logic [EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [ROW_AW-1:0]      sweep_reg, sweep_next;
    logic                   sweep_vec_reg, sweep_vec_next;
    val_t                   prod_reg, prod_next;
    val_t                   sum_reg, sum_next;
    logic                   tr_neg_reg, tr_neg_next;
    logic [VAL_W-1:0]       div_d_reg, div_d_next;
    logic [VAL_W-1:0]       div_q_reg, div_q_next;
    logic [1:0]             div_r_reg, div_r_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;

    logic [ROW_W-1:0]       row_mem [MAX_ATOMS];
    logic [EPOCH_W-1:0]     tag_mem [MAX_ATOMS];
    logic [ROW_W-1:0]       row_rd_reg;
    logic [EPOCH_W-1:0]     tag_rd_reg;
    logic                   mem_re, row_we, tag_we;
    logic [ROW_AW-1:0]      mem_addr;
    logic [ROW_W-1:0]       mem_wrow;
    logic [EPOCH_W-1:0]     mem_wtag;

    logic signed [FIX_W-1:0] sep_a, sep_b;
    logic [ATOM_W-1:0]      t_idx;
    logic                   row_ok;
    val_t                   old_v;
    val_t                   trace_v;
    logic [DIV_NUM_W-1:0]   dv_n, dv_rem;
    logic [2*DIV_NUM_W-1:0] dv_p;
    logic [DIV_CHUNK-1:0]   dv_qd;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[mem_addr] <= mem_wrow;
        end
        if (tag_we) begin
            tag_mem[mem_addr] <= mem_wtag;
        end
        if (mem_re) begin
            row_rd_reg <= row_mem[mem_addr];
            tag_rd_reg <= tag_mem[mem_addr];
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        comp_next      = comp_reg;
        sel_next       = sel_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        s_next         = s_reg;
        glob_next      = glob_reg;
        epoch_next     = epoch_reg;
        sweep_next     = sweep_reg;
        sweep_vec_next = sweep_vec_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        tr_neg_next    = tr_neg_reg;
        div_d_next     = div_d_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        div_cnt_next   = div_cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        q_pop          = 1'b0;
        mem_re         = 1'b0;
        row_we         = 1'b0;
        tag_we         = 1'b0;
        mem_addr       = '0;
        mem_wrow       = '0;
        mem_wtag       = '0;
        ms_req.start   = 1'b0;
        ms_req.a       = '0;
        ms_req.bmag    = '0;
        ms_req.bneg    = 1'b0;
        ms_req.s17     = 1'b0;
        old_v          = '0;
        // one 16-bit digit of the divide by three: remainder in front, reciprocal multiply
        dv_n           = {div_r_reg, div_d_reg[VAL_W-1 -: DIV_CHUNK]};
        dv_p           = dv_n * DIV_RECIP;
        dv_qd          = dv_p[DIV_RECIP_SH +: DIV_CHUNK];
        dv_rem         = dv_n - {2'b00, dv_qd} - {1'b0, dv_qd, 1'b0};
        t_idx          = sel_reg ? cmd_reg.ib : cmd_reg.ia;
        row_ok         = (tag_rd_reg == epoch_reg) && (epoch_reg != '0);
        trace_v        = (cmd_reg.kind == KIND_GLOB)
                         ? (tr_neg_reg ? val_t'(-div_q_reg) : val_t'(div_q_reg)) : '0;

        unique case (comp_reg)
            3'd0:    begin sep_a = cmd_reg.dx; sep_b = cmd_reg.dx; end
            3'd1:    begin sep_a = cmd_reg.dy; sep_b = cmd_reg.dy; end
            3'd2:    begin sep_a = cmd_reg.dz; sep_b = cmd_reg.dz; end
            3'd3:    begin sep_a = cmd_reg.dx; sep_b = cmd_reg.dy; end
            3'd4:    begin sep_a = cmd_reg.dx; sep_b = cmd_reg.dz; end
            default: begin sep_a = cmd_reg.dy; sep_b = cmd_reg.dz; end
        endcase

        unique case (state_reg)
            BK_SWEEP: begin
                tag_we     = 1'b1;
                mem_addr   = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == ROW_AW'(MAX_ATOMS - 1)) begin
                    sweep_next     = '0;
                    sweep_vec_next = 1'b0;
                    state_next     = sweep_vec_reg ? BK_VSEP : BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_dout;
                    comp_next = '0;
                    sel_next  = 1'b0;
                    unique case (q_dout.kind)
                        KIND_PAIR: begin
                            state_next = BK_VSEP;
                            if (q_dout.clear) begin
                                for (int c = 0; c < COMPONENTS; c++) begin
                                    glob_next[c] = '0;
                                end
                                // tags wrap: wipe them so stale rows never match
                                if (epoch_reg == '1) begin
                                    epoch_next     = EPOCH_W'(1);
                                    sweep_vec_next = 1'b1;
                                    state_next     = BK_SWEEP;
                                end else begin
                                    epoch_next = epoch_reg + 1'b1;
                                end
                            end
                        end
                        KIND_ROW: state_next = BK_RRD;
                        KIND_GLOB: begin
                            w_next     = glob_reg;
                            state_next = BK_SGO;
                        end
                        default: state_next = BK_IDLE;
                    endcase
                end
            end
            BK_VSEP: begin
                prod_next  = VAL_W'(sep_a) * VAL_W'(sep_b);
                state_next = BK_VGO;
            end
            BK_VGO: begin
                ms_req.start = 1'b1;
                ms_req.a     = prod_reg;
                ms_req.bmag  = cmd_reg.force_v[FIX_W-1] ? FIX_W'(-cmd_reg.force_v)
                                                        : FIX_W'(cmd_reg.force_v);
                ms_req.bneg  = cmd_reg.force_v[FIX_W-1];
                ms_req.s17   = 1'b1;
                state_next   = BK_VWAIT;
            end
            BK_VWAIT: begin
                if (ms_rsp.done) begin
                    v_next[comp_reg] = ms_rsp.res;
                    if (comp_reg == COMP_W'(COMPONENTS - 1)) begin
                        comp_next  = '0;
                        state_next = BK_TRD;
                    end else begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = BK_VSEP;
                    end
                end
            end
            BK_TRD: begin
                if (sel_reg ? cmd_reg.tally_b : cmd_reg.tally_a) begin
                    mem_re     = 1'b1;
                    mem_addr   = ROW_AW'(t_idx);
                    state_next = BK_TWR;
                end else if (sel_reg) begin
                    state_next = BK_IDLE;
                end else begin
                    sel_next = 1'b1;
                end
            end
            BK_TWR: begin
                row_we   = 1'b1;
                tag_we   = 1'b1;
                mem_addr = ROW_AW'(t_idx);
                mem_wtag = epoch_reg;
                for (int c = 0; c < COMPONENTS; c++) begin
                    old_v = row_ok ? val_t'(row_rd_reg[c*VAL_W +: VAL_W]) : '0;
                    mem_wrow[c*VAL_W +: VAL_W] = sat_add(old_v, v_reg[c]);
                    glob_next[c] = sat_add(glob_reg[c], v_reg[c]);
                end
                if (sel_reg) begin
                    state_next = BK_IDLE;
                end else begin
                    sel_next   = 1'b1;
                    state_next = BK_TRD;
                end
            end
            BK_RRD: begin
                mem_re     = 1'b1;
                mem_addr   = ROW_AW'(cmd_reg.ia);
                state_next = BK_RLOAD;
            end
            BK_RLOAD: begin
                for (int c = 0; c < COMPONENTS; c++) begin
                    w_next[c] = (row_ok && cmd_reg.ia_ok)
                                ? val_t'(row_rd_reg[c*VAL_W +: VAL_W]) : '0;
                end
                comp_next  = '0;
                state_next = BK_SGO;
            end
            BK_SGO: begin
                ms_req.start = 1'b1;
                ms_req.a     = w_reg[comp_reg];
                ms_req.bmag  = pressure_scale;
                ms_req.bneg  = 1'b1;
                ms_req.s17   = 1'b0;
                state_next   = BK_SWAIT;
            end
            BK_SWAIT: begin
                if (ms_rsp.done) begin
                    s_next[comp_reg] = ms_rsp.res;
                    if (comp_reg == COMP_W'(COMPONENTS - 1)) begin
                        comp_next  = '0;
                        state_next = (cmd_reg.kind == KIND_GLOB) ? BK_TR1 : BK_OUT;
                    end else begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = BK_SGO;
                    end
                end
            end
            BK_TR1: begin
                sum_next   = sat_add(s_reg[0], s_reg[1]);
                state_next = BK_TR2;
            end
            BK_TR2: begin
                sum_next   = sat_add(sum_reg, s_reg[2]);
                state_next = BK_DIVINIT;
            end
            BK_DIVINIT: begin
                tr_neg_next  = sum_reg[VAL_W-1];
                div_d_next   = sum_reg[VAL_W-1] ? VAL_W'(-sum_reg) : VAL_W'(sum_reg);
                div_q_next   = '0;
                div_r_next   = '0;
                div_cnt_next = '0;
                state_next   = BK_DIV;
            end
            BK_DIV: begin
                div_d_next   = div_d_reg << DIV_CHUNK;
                div_q_next   = {div_q_reg[VAL_W-DIV_CHUNK-1:0], dv_qd};
                div_r_next   = dv_rem[1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_CYC - 1)) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {trace_v, s_reg[5], s_reg[4], s_reg[3],
                                    s_reg[2], s_reg[1], s_reg[0]};
                    state_next   = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        v_reg       <= v_next;
        w_reg       <= w_next;
        s_reg       <= s_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        tr_neg_reg  <= tr_neg_next;
        div_d_reg   <= div_d_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_SWEEP;
            comp_reg      <= '0;
            sel_reg       <= 1'b0;
            epoch_reg     <= '0;
            sweep_reg     <= '0;
            sweep_vec_reg <= 1'b0;
            div_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            for (int c = 0; c < COMPONENTS; c++) begin
                glob_reg[c] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            sel_reg       <= sel_next;
            epoch_reg     <= epoch_next;
            sweep_reg     <= sweep_next;
            sweep_vec_reg <= sweep_vec_next;
            div_cnt_reg   <= div_cnt_next;
            m_valid_reg   <= m_valid_next;
            glob_reg      <= glob_next;
        end
    end

endmodule

@@ sv/pair_virial_stress_tally.sv @@
// Channel   Dir  Beat contents
// s_*       in   tuser: kind; tdata: timestep, atoms, local count, newton, force, separation
// m_*       out  tdata: six scaled components, trace over three
// cfg_*     in   pressure_scale, written when cfg_we is high
//
// Pair beat: six products on the shared multiply unit, then a row read and a row
// write per tallied atom. Row read: six scalings; global read: six scalings,
// two adds and a digit-serial divide by three.
// After reset, and after every 255th new timestep, a pass over all 4096 rows
// clears the row tags; input beats wait in a 2-entry queue meanwhile.
// A stalled m_tready holds one result; the queue keeps taking beats until full.
module pair_virial_stress_tally (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // timestep, atom_first, atom_second, local_count, newton_on,
    // pair_force, sep_x, sep_y, sep_z, 2 pad bits
    input  logic [pvst_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_xx, out_yy, out_zz, out_xy, out_xz, out_yz, out_trace_third
    output logic [pvst_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [pvst_pkg::FIX_W-1:0]      cfg_wdata
);
    import pvst_pkg::*;

    logic [FIX_W-1:0] pscale_reg, pscale_next;
    logic             q_full, q_push, q_pop, q_empty;
    cmd_t             q_din, q_dout;
    ms_req_t          ms_req;
    ms_rsp_t          ms_rsp;

    assign pscale_next = cfg_we ? cfg_wdata : pscale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pscale_reg <= FIX_W'(65536);
        end else begin
            pscale_reg <= pscale_next;
        end
    end

    pvst_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_din    (q_din)
    );

    pvst_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    pvst_mulsh u_mulsh (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ms_req),
        .rsp     (ms_rsp)
    );

    pvst_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pressure_scale (pscale_reg),
        .q_empty        (q_empty),
        .q_dout         (q_dout),
        .q_pop          (q_pop),
        .ms_req         (ms_req),
        .ms_rsp         (ms_rsp),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule
